// ----- hdl/tapd_pkg.sv -----
`default_nettype none

package tapd_pkg;

   // Fixed-point constants, Q4.12
   localparam logic signed [16:0] PI_Q      = 17'sd12868;
   localparam logic signed [16:0] NEG_PI_Q  = -17'sd12868;
   localparam logic signed [16:0] TWO_PI_Q  = 17'sd25736;
   localparam int unsigned        FRAC_BITS = 12;

   // Register reset values
   localparam logic [15:0] ROLL_P_RESET  = 16'd819;
   localparam logic [15:0] ROLL_D_RESET  = 16'd819;
   localparam logic [15:0] PITCH_P_RESET = 16'd819;
   localparam logic [15:0] PITCH_D_RESET = 16'd819;
   localparam logic [15:0] YAW_P_RESET   = 16'd8192;
   localparam logic [15:0] YAW_D_RESET   = 16'd12288;
   localparam logic [15:0] INV_DT_RESET  = 16'd1000;

   typedef enum logic [2:0] {
      CSR_ROLL_P  = 3'd0,
      CSR_ROLL_D  = 3'd1,
      CSR_PITCH_P = 3'd2,
      CSR_PITCH_D = 3'd3,
      CSR_YAW_P   = 3'd4,
      CSR_YAW_D   = 3'd5,
      CSR_INV_DT  = 3'd6
   } csr_index_type;

   // Operand pair for the shared multiplier
   typedef enum logic [2:0] {
      MUL_YAW_DT,
      MUL_ROLL_P,
      MUL_ROLL_D,
      MUL_PITCH_P,
      MUL_PITCH_D,
      MUL_YAW_P,
      MUL_YAW_D_LO,
      MUL_YAW_D_HI
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_ADD_HIGH
   } acc_op_type;

   typedef struct packed {
      logic        capture;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        rate_load;
      logic        roll_store;
      logic        pitch_store;
      logic        publish;
   } tapd_cmd_type;

   // Target minus measured, moved once by 2*pi toward zero, clamped to 16 bits
   function automatic logic [15:0] wrap_error(input logic [15:0] target,
                                              input logic [15:0] measured);
      logic signed [16:0] e;
      e = $signed({target[15], target}) - $signed({measured[15], measured});
      if (e > PI_Q) begin
         e = e - TWO_PI_Q;
      end else if (e < NEG_PI_Q) begin
         e = e + TWO_PI_Q;
      end
      if (e[16] != e[15]) begin
         wrap_error = e[16] ? 16'h8000 : 16'h7FFF;
      end else begin
         wrap_error = e[15:0];
      end
   endfunction

   // Floor shift by FRAC_BITS, clamp to 24 bits
   function automatic logic [23:0] sat_torque(input logic [51:0] acc);
      logic [39:0] q;
      q = acc[51:FRAC_BITS];
      if (q[39:23] != {17{q[23]}}) begin
         sat_torque = q[39] ? 24'h800000 : 24'h7FFFFF;
      end else begin
         sat_torque = q[23:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- hdl/tapd_ctrl.sv -----
`default_nettype none

module tapd_ctrl
   import tapd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output tapd_cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_PUBLISH
   } state_type;

   localparam logic [3:0] LAST_STEP = 4'd8;

   state_type  state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd             = '0;
      cmd.mul_sel     = MUL_YAW_DT;
      cmd.acc_op      = ACC_HOLD;
      cmd.capture     = req_valid && req_ready;
      if (state_ff == ST_RUN) begin
         case (step_ff)
            4'd0: cmd.mul_sel = MUL_YAW_DT;
            4'd1: begin
               cmd.mul_sel   = MUL_ROLL_P;
               cmd.rate_load = 1'b1;
            end
            4'd2: begin
               cmd.mul_sel = MUL_ROLL_D;
               cmd.acc_op  = ACC_LOAD;
            end
            4'd3: begin
               cmd.mul_sel = MUL_PITCH_P;
               cmd.acc_op  = ACC_ADD;
            end
            4'd4: begin
               cmd.mul_sel    = MUL_PITCH_D;
               cmd.acc_op     = ACC_LOAD;
               cmd.roll_store = 1'b1;
            end
            4'd5: begin
               cmd.mul_sel = MUL_YAW_P;
               cmd.acc_op  = ACC_ADD;
            end
            4'd6: begin
               cmd.mul_sel     = MUL_YAW_D_LO;
               cmd.acc_op      = ACC_LOAD;
               cmd.pitch_store = 1'b1;
            end
            4'd7: begin
               cmd.mul_sel = MUL_YAW_D_HI;
               cmd.acc_op  = ACC_ADD;
            end
            4'd8: cmd.acc_op = ACC_ADD_HIGH;
            default: cmd.acc_op = ACC_HOLD;
         endcase
      end
      cmd.publish = (state_ff == ST_PUBLISH) && slot_free;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_PUBLISH;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_PUBLISH: begin
            // hold until the output slot is free
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/tapd_datapath.sv -----
`default_nettype none

module tapd_datapath
   import tapd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire tapd_cmd_type cmd,
   input  wire logic         csr_write_enable,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_write_data,
   input  wire logic [15:0]  req_roll_target,
   input  wire logic [15:0]  req_pitch_target,
   input  wire logic [15:0]  req_yaw_target,
   input  wire logic [15:0]  req_roll_measured,
   input  wire logic [15:0]  req_pitch_measured,
   input  wire logic [15:0]  req_yaw_measured,
   input  wire logic [15:0]  req_roll_rate,
   input  wire logic [15:0]  req_pitch_rate,
   input  wire logic [15:0]  req_yaw_rate,
   output logic [23:0]       rsp_roll_torque,
   output logic [23:0]       rsp_pitch_torque,
   output logic [23:0]       rsp_yaw_torque,
   output logic [15:0]       rsp_roll_error,
   output logic [15:0]       rsp_pitch_error,
   output logic [15:0]       rsp_yaw_error
);

   // Gains and inverse time step
   logic [15:0] roll_p_ff, roll_d_ff, pitch_p_ff, pitch_d_ff;
   logic [15:0] yaw_p_ff, yaw_d_ff, inv_dt_ff;
   logic [15:0] prev_yaw_ff;

   // Captured request
   logic [15:0] roll_err_ff, pitch_err_ff, yaw_err_ff;
   logic [16:0] roll_rneg_ff, pitch_rneg_ff;
   logic [16:0] yaw_diff_ff;
   logic [15:0] yaw_rate_ff;

   logic [33:0] rate_ff;
   logic [34:0] prod_ff;
   logic [51:0] acc_ff;
   logic [23:0] roll_torque_ff, pitch_torque_ff;

   logic signed [16:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [34:0] prod_in;

   logic [23:0] roll_torque_out_ff, pitch_torque_out_ff, yaw_torque_out_ff;
   logic [15:0] roll_err_out_ff, pitch_err_out_ff, yaw_err_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_p_ff   <= ROLL_P_RESET;
         roll_d_ff   <= ROLL_D_RESET;
         pitch_p_ff  <= PITCH_P_RESET;
         pitch_d_ff  <= PITCH_D_RESET;
         yaw_p_ff    <= YAW_P_RESET;
         yaw_d_ff    <= YAW_D_RESET;
         inv_dt_ff   <= INV_DT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_ROLL_P:  roll_p_ff  <= csr_write_data;
            CSR_ROLL_D:  roll_d_ff  <= csr_write_data;
            CSR_PITCH_P: pitch_p_ff <= csr_write_data;
            CSR_PITCH_D: pitch_d_ff <= csr_write_data;
            CSR_YAW_P:   yaw_p_ff   <= csr_write_data;
            CSR_YAW_D:   yaw_d_ff   <= csr_write_data;
            CSR_INV_DT:  inv_dt_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_yaw_ff <= '0;
      end else if (cmd.capture) begin
         prev_yaw_ff <= req_yaw_target;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         roll_err_ff   <= wrap_error(req_roll_target, req_roll_measured);
         pitch_err_ff  <= wrap_error(req_pitch_target, req_pitch_measured);
         yaw_err_ff    <= wrap_error(req_yaw_target, req_yaw_measured);
         roll_rneg_ff  <= 17'd0 - {req_roll_rate[15], req_roll_rate};
         pitch_rneg_ff <= 17'd0 - {req_pitch_rate[15], req_pitch_rate};
         yaw_diff_ff   <= {req_yaw_target[15], req_yaw_target}
                          - {prev_yaw_ff[15], prev_yaw_ff};
         yaw_rate_ff   <= req_yaw_rate;
      end
   end

   always_comb begin
      mul_a = $signed({1'b0, roll_p_ff});
      mul_b = $signed({{2{roll_err_ff[15]}}, roll_err_ff});
      case (cmd.mul_sel)
         MUL_YAW_DT: begin
            mul_a = $signed(yaw_diff_ff);
            mul_b = $signed({2'b00, inv_dt_ff});
         end
         MUL_ROLL_P: begin
            mul_a = $signed({1'b0, roll_p_ff});
            mul_b = $signed({{2{roll_err_ff[15]}}, roll_err_ff});
         end
         MUL_ROLL_D: begin
            mul_a = $signed({1'b0, roll_d_ff});
            mul_b = $signed({roll_rneg_ff[16], roll_rneg_ff});
         end
         MUL_PITCH_P: begin
            mul_a = $signed({1'b0, pitch_p_ff});
            mul_b = $signed({{2{pitch_err_ff[15]}}, pitch_err_ff});
         end
         MUL_PITCH_D: begin
            mul_a = $signed({1'b0, pitch_d_ff});
            mul_b = $signed({pitch_rneg_ff[16], pitch_rneg_ff});
         end
         MUL_YAW_P: begin
            mul_a = $signed({1'b0, yaw_p_ff});
            mul_b = $signed({{2{yaw_err_ff[15]}}, yaw_err_ff});
         end
         MUL_YAW_D_LO: begin
            mul_a = $signed({1'b0, yaw_d_ff});
            mul_b = $signed({1'b0, rate_ff[16:0]});
         end
         MUL_YAW_D_HI: begin
            mul_a = $signed({1'b0, yaw_d_ff});
            mul_b = $signed({rate_ff[33], rate_ff[33:17]});
         end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.rate_load) begin
         rate_ff <= prod_ff[33:0] - {{18{yaw_rate_ff[15]}}, yaw_rate_ff};
      end
      case (cmd.acc_op)
         ACC_LOAD:     acc_ff <= {{17{prod_ff[34]}}, prod_ff};
         ACC_ADD:      acc_ff <= acc_ff + {{17{prod_ff[34]}}, prod_ff};
         ACC_ADD_HIGH: acc_ff <= acc_ff + {prod_ff, 17'd0};
         default: ;
      endcase
      if (cmd.roll_store) begin
         roll_torque_ff <= sat_torque(acc_ff);
      end
      if (cmd.pitch_store) begin
         pitch_torque_ff <= sat_torque(acc_ff);
      end
      if (cmd.publish) begin
         roll_torque_out_ff  <= roll_torque_ff;
         pitch_torque_out_ff <= pitch_torque_ff;
         yaw_torque_out_ff   <= sat_torque(acc_ff);
         roll_err_out_ff     <= roll_err_ff;
         pitch_err_out_ff    <= pitch_err_ff;
         yaw_err_out_ff      <= yaw_err_ff;
      end
   end

   assign rsp_roll_torque  = roll_torque_out_ff;
   assign rsp_pitch_torque = pitch_torque_out_ff;
   assign rsp_yaw_torque   = yaw_torque_out_ff;
   assign rsp_roll_error   = roll_err_out_ff;
   assign rsp_pitch_error  = pitch_err_out_ff;
   assign rsp_yaw_error    = yaw_err_out_ff;

endmodule

`default_nettype wire

// ----- hdl/three_axis_attitude_pd_control_core.sv -----
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  targets, measured angles, rates (16b Q4.12)
// rsp       out        rsp_valid / rsp_ready  torques (24b Q12.12), wrapped errors (16b)
// csr       in         csr_write_enable       csr_index (3b), csr_write_data (16b)
//
// After a request is accepted, it runs nine steps through
// the single 17x18 multiplier and its accumulator, then the publish state. The next
// request is taken only back in idle, so one request is in flight at a time.
// Eight products share that multiplier; the desired yaw rate product
// is 34 bits wide, so its derivative term goes through in two halves.
// Synchronous active-high reset restores the gains and clears the last yaw target.
// A pending result does not block acceptance; a finished request waits in
// publish until the output register frees up.
`default_nettype none

module three_axis_attitude_pd_control_core
   import tapd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_roll_target,
   input  wire logic [15:0] req_pitch_target,
   input  wire logic [15:0] req_yaw_target,
   input  wire logic [15:0] req_roll_measured,
   input  wire logic [15:0] req_pitch_measured,
   input  wire logic [15:0] req_yaw_measured,
   input  wire logic [15:0] req_roll_rate,
   input  wire logic [15:0] req_pitch_rate,
   input  wire logic [15:0] req_yaw_rate,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [23:0]      rsp_roll_torque,
   output logic [23:0]      rsp_pitch_torque,
   output logic [23:0]      rsp_yaw_torque,
   output logic [15:0]      rsp_roll_error,
   output logic [15:0]      rsp_pitch_error,
   output logic [15:0]      rsp_yaw_error,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   // Sequencer commands to the datapath
   tapd_cmd_type cmd;

   tapd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Errors, shared multiplier, accumulator and the output register
   tapd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_roll_target    (req_roll_target),
      .req_pitch_target   (req_pitch_target),
      .req_yaw_target     (req_yaw_target),
      .req_roll_measured  (req_roll_measured),
      .req_pitch_measured (req_pitch_measured),
      .req_yaw_measured   (req_yaw_measured),
      .req_roll_rate      (req_roll_rate),
      .req_pitch_rate     (req_pitch_rate),
      .req_yaw_rate       (req_yaw_rate),
      .rsp_roll_torque    (rsp_roll_torque),
      .rsp_pitch_torque   (rsp_pitch_torque),
      .rsp_yaw_torque     (rsp_yaw_torque),
      .rsp_roll_error     (rsp_roll_error),
      .rsp_pitch_error    (rsp_pitch_error),
      .rsp_yaw_error      (rsp_yaw_error)
   );

endmodule

`default_nettype wire

// ----- hdl/tapd_checker.sv -----
`default_nettype none

module tapd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [23:0] rsp_yaw_torque
);

   // Result held until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_yaw_torque))
      else $error("rsp dropped or changed while stalled");

   // Reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // One request in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after acceptance");

   // No result appears in the cycle after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("rsp appeared too early");

endmodule

bind three_axis_attitude_pd_control_core tapd_checker u_tapd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_yaw_torque (rsp_yaw_torque)
);

`default_nettype wire

// ----- tb/sv/three_axis_attitude_pd_control_core_tb.sv -----
`timescale 1ns / 100ps

module three_axis_attitude_pd_control_core_tb;
   import tapd_pkg::*;

   localparam int PHASES             = 8;
   localparam int REQUESTS_PER_PHASE = 82;
   localparam int IDLE_LIMIT         = 1000;  // cycles with no handshake and no write
   localparam int DRAIN_CYCLES       = 16;    // after the last queued command arrives
   localparam int REPORT_LIMIT       = 10;
   localparam int HALF_TURN          = 12868; // pi in Q4.12
   localparam int FULL_TURN          = 25736;
   localparam longint TORQUE_HIGH    = 64'sd8388607;
   localparam longint TORQUE_LOW     = -64'sd8388608;
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [15:0] roll_target, pitch_target, yaw_target;
      logic [15:0] roll_measured, pitch_measured, yaw_measured;
      logic [15:0] roll_rate, pitch_rate, yaw_rate;
   } attitude_request_type;

   typedef struct packed {
      logic [23:0] roll_torque, pitch_torque, yaw_torque;
      logic [15:0] roll_error, pitch_error, yaw_error;
   } torque_command_type;

   typedef struct {
      attitude_request_type request;
      bit                   typed;
      torque_command_type   command;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_roll_target = '0;
   logic [15:0] req_pitch_target = '0;
   logic [15:0] req_yaw_target = '0;
   logic [15:0] req_roll_measured = '0;
   logic [15:0] req_pitch_measured = '0;
   logic [15:0] req_yaw_measured = '0;
   logic [15:0] req_roll_rate = '0;
   logic [15:0] req_pitch_rate = '0;
   logic [15:0] req_yaw_rate = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [23:0] rsp_roll_torque;
   logic [23:0] rsp_pitch_torque;
   logic [23:0] rsp_yaw_torque;
   logic [15:0] rsp_roll_error;
   logic [15:0] rsp_pitch_error;
   logic [15:0] rsp_yaw_error;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_write_data = '0;

   // Controller state as the block should hold it
   logic [15:0]        gain_model [8];
   logic [15:0]        last_yaw_target;
   torque_command_type expected_commands [$];

   int mismatch_count = 0;
   int commands_seen  = 0;
   int idle_cycles    = 0;
   int stall_left     = 0;
   bit steady_flow    = 1'b0;

   three_axis_attitude_pd_control_core i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // Target minus measured, moved once by a full turn toward zero, clamped to 16 bits
   function automatic logic [15:0] wrapped_error(logic [15:0] target, logic [15:0] measured);
      int e;
      e = int'($signed(target)) - int'($signed(measured));
      if (e > HALF_TURN) begin
         e -= FULL_TURN;
      end else if (e < -HALF_TURN) begin
         e += FULL_TURN;
      end
      if (e > 32767) e = 32767;
      if (e < -32768) e = -32768;
      return e[15:0];
   endfunction

   // Exact Q.24 sum of both terms, floor to Q12.12, clamp to 24 bits
   function automatic logic [23:0] pd_torque(logic [15:0] p_gain, logic [15:0] angle_error,
                                             logic [15:0] d_gain, longint rate_error);
      longint acc;
      longint q;
      acc = longint'(p_gain) * longint'($signed(angle_error))
          + longint'(d_gain) * rate_error;
      q = acc >>> 12;
      if (q > TORQUE_HIGH) q = TORQUE_HIGH;
      if (q < TORQUE_LOW) q = TORQUE_LOW;
      return q[23:0];
   endfunction

   // Predict the command, and advance the last yaw target as the block does on each accepted request
   task automatic predict_command(input attitude_request_type r,
                                  output torque_command_type c);
      longint yaw_rate_demand;
      c.roll_error  = wrapped_error(r.roll_target, r.roll_measured);
      c.pitch_error = wrapped_error(r.pitch_target, r.pitch_measured);
      c.yaw_error   = wrapped_error(r.yaw_target, r.yaw_measured);
      yaw_rate_demand = (longint'($signed(r.yaw_target)) - longint'($signed(last_yaw_target)))
                      * longint'(gain_model[CSR_INV_DT]);
      last_yaw_target = r.yaw_target;
      c.roll_torque  = pd_torque(gain_model[CSR_ROLL_P], c.roll_error,
                                 gain_model[CSR_ROLL_D], -longint'($signed(r.roll_rate)));
      c.pitch_torque = pd_torque(gain_model[CSR_PITCH_P], c.pitch_error,
                                 gain_model[CSR_PITCH_D], -longint'($signed(r.pitch_rate)));
      c.yaw_torque   = pd_torque(gain_model[CSR_YAW_P], c.yaw_error, gain_model[CSR_YAW_D],
                                 yaw_rate_demand - longint'($signed(r.yaw_rate)));
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   // Mostly back to back (always in steady flow), sometimes a short gap, now and then a long hole
   function automatic int idle_gap();
      int pick;
      if (steady_flow) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [15:0] test_word();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'(int'($urandom_range(0, 1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   // Offset between target and measured: small, right at pi, beyond pi, or anything
   function automatic logic [15:0] angle_delta();
      int magnitude;
      case ($urandom_range(0, 3))
         0: magnitude = $urandom_range(0, 1500);
         1: magnitude = HALF_TURN - 1 + $urandom_range(0, 2);
         2: magnitude = $urandom_range(HALF_TURN + 2, 32767);
         default: return 16'($urandom);
      endcase
      return ($urandom_range(0, 1) != 0) ? 16'(-magnitude) : 16'(magnitude);
   endfunction

   task automatic random_request(output attitude_request_type r);
      if ($urandom_range(0, 9) == 0) begin
         // Noise: every field independent
         for (int k = 0; k < 9; k++) r[k*16 +: 16] = 16'($urandom);
      end else begin
         r.roll_measured  = test_word();
         r.roll_target    = r.roll_measured + angle_delta();
         r.pitch_measured = test_word();
         r.pitch_target   = r.pitch_measured + angle_delta();
         r.yaw_measured   = test_word();
         // Half the time step the yaw target smoothly from the last one
         if ($urandom_range(0, 1) != 0) begin
            r.yaw_target = last_yaw_target + 16'($urandom_range(0, 400)) - 16'd200;
         end else begin
            r.yaw_target = r.yaw_measured + angle_delta();
         end
         r.roll_rate  = test_word();
         r.pitch_rate = test_word();
         r.yaw_rate   = test_word();
      end
   endtask

   function automatic directed_row_type angle_row(int rt, int pt, int yt, int rm, int pm,
                                                  int ym, int rr, int pr, int yr);
      directed_row_type d;
      d.request = {16'(rt), 16'(pt), 16'(yt), 16'(rm), 16'(pm), 16'(ym),
                   16'(rr), 16'(pr), 16'(yr)};
      d.typed   = 1'b0;
      d.command = '0;
      return d;
   endfunction

   function automatic directed_row_type with_command(directed_row_type d, int roll_trq,
                                                     int pitch_trq, int yaw_trq, int roll_err,
                                                     int pitch_err, int yaw_err);
      d.typed   = 1'b1;
      d.command = {24'(roll_trq), 24'(pitch_trq), 24'(yaw_trq),
                   16'(roll_err), 16'(pitch_err), 16'(yaw_err)};
      return d;
   endfunction

   function automatic string command_text(torque_command_type c);
      return $sformatf("torque %0d %0d %0d error %0d %0d %0d",
                       $signed(c.roll_torque), $signed(c.pitch_torque), $signed(c.yaw_torque),
                       $signed(c.roll_error), $signed(c.pitch_error), $signed(c.yaw_error));
   endfunction

   // Hold valid and payload until the request is taken, then queue its command
   task automatic send_request(input attitude_request_type r, input bit typed,
                               input torque_command_type typed_command);
      torque_command_type predicted;
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_roll_target, req_pitch_target, req_yaw_target,
       req_roll_measured, req_pitch_measured, req_yaw_measured,
       req_roll_rate, req_pitch_rate, req_yaw_rate} <= r;
      do @(posedge clock); while (!req_ready);
      // Predict anyway so the yaw history stays in step on typed rows
      predict_command(r, predicted);
      expected_commands.push_back(typed ? typed_command : predicted);
   endtask

   // Drop valid, wait for every queued command, then let the pipeline settle
   task automatic drain_commands();
      req_valid <= 1'b0;
      while (expected_commands.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      if (index != CSR_UNUSED) gain_model[index] = value;
   endtask

   // ---------------------------------------------------------------- command check

   always @(posedge clock) begin : command_check
      torque_command_type got;
      torque_command_type want;
      int gap;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_roll_torque, rsp_pitch_torque, rsp_yaw_torque,
                   rsp_roll_error, rsp_pitch_error, rsp_yaw_error};
            commands_seen++;
            if (expected_commands.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("command %0d arrived with none pending: %s",
                           commands_seen, command_text(got));
            end else begin
               want = expected_commands.pop_front();
               if (got.roll_torque !== want.roll_torque ||
                   got.pitch_torque !== want.pitch_torque ||
                   got.yaw_torque !== want.yaw_torque ||
                   got.roll_error !== want.roll_error ||
                   got.pitch_error !== want.pitch_error ||
                   got.yaw_error !== want.yaw_error) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("command %0d mismatch: expected %s, got %s",
                              commands_seen, command_text(want), command_text(got));
               end
            end
         end
         // Stall the response side the same way the request side idles
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            gap = idle_gap();
            rsp_ready <= (gap == 0);
            if (gap > 0) stall_left = gap - 1;
         end
      end
   end

   // End the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL three_axis_attitude_pd_control_core");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin : stimulus
      directed_row_type     directed [$];
      attitude_request_type r;
      logic [15:0]          setting [7];

      gain_model[CSR_ROLL_P]  = ROLL_P_RESET;
      gain_model[CSR_ROLL_D]  = ROLL_D_RESET;
      gain_model[CSR_PITCH_P] = PITCH_P_RESET;
      gain_model[CSR_PITCH_D] = PITCH_D_RESET;
      gain_model[CSR_YAW_P]   = YAW_P_RESET;
      gain_model[CSR_YAW_D]   = YAW_D_RESET;
      gain_model[CSR_INV_DT]  = INV_DT_RESET;
      last_yaw_target         = '0;

      // Rows with a typed command rely on reset gains and a zero yaw history
      directed.push_back(with_command(angle_row(0, 0, 0, 0, 0, 0, 0, 0, 0),
                                      0, 0, 0, 0, 0, 0));
      // Widest angle errors: one wrap is not enough, so the error clamps
      directed.push_back(with_command(angle_row(32767, -32768, 0, -32768, 32767, 0, 0, 0, 0),
                                      6551, -6552, 0, 32767, -32768, 0));
      // Rate extremes only
      directed.push_back(with_command(angle_row(0, 0, 0, 0, 0, 0, -32768, 32767, -32768),
                                      6552, -6552, 98304, 0, 0, 0));
      // Full-scale yaw target jumps saturate the yaw torque both ways
      directed.push_back(with_command(angle_row(0, 0, 32767, 0, 0, 32767, 0, 0, 0),
                                      0, 0, 8388607, 0, 0, 0));
      directed.push_back(with_command(angle_row(0, 0, -32768, 0, 0, -32768, 0, 0, 0),
                                      0, 0, -8388608, 0, 0, 0));
      directed.push_back(angle_row(0, 0, 0, 0, 0, 0, 0, 0, 0));
      // Either side of the pi boundary
      directed.push_back(angle_row(12868, 12869, -12868, 0, 0, 0, 0, 0, 0));
      directed.push_back(angle_row(-12869, -12868, 12869, 0, 0, 0, 0, 0, 0));
      directed.push_back(angle_row(0, 0, -12869, -12868, 12869, 0, 100, -100, 0));
      directed.push_back(angle_row(25736, -25736, 12868, 0, 0, -12868, 1, 1, 1));
      directed.push_back(angle_row(32767, 32767, 32767, 32767, 32767, 32767,
                                   32767, 32767, 32767));
      directed.push_back(angle_row(-32768, -32768, -32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768));
      directed.push_back(angle_row(32767, -32768, 32767, -32768, 32767, -32768, 0, 0, 0));
      directed.push_back(angle_row(-32768, 32767, -32768, 32767, -32768, 32767, -1, -1, -1));
      directed.push_back(angle_row(-20000, 20000, -20000, 20000, -20000, 20000, 0, 0, 0));
      directed.push_back(angle_row(-1, 1, 5, 1, -1, 0, 4096, -4096, 2048));
      directed.push_back(angle_row(100, 200, 10, 0, 0, 0, 0, 0, -32768));
      directed.push_back(angle_row(100, 200, 11, 0, 0, 0, 0, 0, 32767));
      directed.push_back(angle_row(0, 0, 0, 0, 0, 0, 0, 0, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_request(directed[i].request, directed[i].typed,
                                         directed[i].command);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_commands();
         case (phase)
            0: begin
               foreach (setting[i]) setting[i] = 16'hFFFF;
            end
            1: begin
               // Zero gains and a zero inverse step
               foreach (setting[i]) setting[i] = 16'h0000;
            end
            2: begin
               foreach (setting[i]) setting[i] = 16'h1000;
               setting[CSR_INV_DT] = 16'd1;
            end
            default: begin
               foreach (setting[i]) setting[i] = 16'($urandom);
               if ($urandom_range(0, 4) == 0) setting[CSR_INV_DT] = '0;
            end
         endcase
         write_register(CSR_ROLL_P, setting[CSR_ROLL_P]);
         write_register(CSR_ROLL_D, setting[CSR_ROLL_D]);
         write_register(CSR_PITCH_P, setting[CSR_PITCH_P]);
         write_register(CSR_PITCH_D, setting[CSR_PITCH_D]);
         write_register(CSR_YAW_P, setting[CSR_YAW_P]);
         write_register(CSR_YAW_D, setting[CSR_YAW_D]);
         write_register(CSR_INV_DT, setting[CSR_INV_DT]);
         // An unmapped index must leave every gain alone
         write_register(CSR_UNUSED, 16'($urandom));
         csr_write_enable <= 1'b0;

         // Run a couple of phases with no idling on either side
         steady_flow = (phase == 3 || phase == 6);
         repeat (REQUESTS_PER_PHASE) begin
            random_request(r);
            send_request(r, 1'b0, '0);
         end
      end

      steady_flow = 1'b0;
      drain_commands();
      if (mismatch_count == 0 && expected_commands.size() == 0) begin
         $display("PASS three_axis_attitude_pd_control_core");
      end else begin
         $display("FAIL three_axis_attitude_pd_control_core");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/tapd_pkg.sv
hdl/tapd_ctrl.sv
hdl/tapd_datapath.sv
hdl/three_axis_attitude_pd_control_core.sv
hdl/tapd_checker.sv
tb/sv/three_axis_attitude_pd_control_core_tb.sv
